[rtl/fcwt_pkg.sv]
// ----------------------------------------------------------------------------
// fcwt_pkg
// Shared types and constants of the flow congestion window tracker.
// ----------------------------------------------------------------------------
package fcwt_pkg;

  localparam logic [15:0] MIN_FRAME      = 16'd54;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;

  localparam logic [15:0] SEG_RESET  = 16'd1460;
  localparam logic [31:0] WIN_RESET  = 32'd14600;
  localparam logic [31:0] THR_RESET  = 32'd65535;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_WINDOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_THRESHOLD = 2'd2;

  // Row operations issued to the cells
  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_MATCH  = 2'd1;
  localparam logic [1:0] OP_BUBBLE = 2'd2;
  localparam logic [1:0] OP_SHIFT  = 2'd3;

  typedef struct packed {
    logic        valid;
    logic        mark;
    logic [63:0] key;
    logic [31:0] window;
    logic [31:0] threshold;
    logic        phase;
  } entry_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] key;
  } cell_ctrl_t;

endpackage

[rtl/fcwt_if.sv]
// ----------------------------------------------------------------------------
// fcwt_frame_if / fcwt_result_if
// Valid/ready channels for frame headers and per-frame results.
// ----------------------------------------------------------------------------
interface fcwt_frame_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_length;
  logic [15:0] ether_type;
  logic [7:0]  ip_protocol;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [15:0] source_port;
  logic [15:0] dest_port;

  modport source (output valid, frame_length, ether_type, ip_protocol, source_address,
                  dest_address, source_port, dest_port, input ready);
  modport sink (input valid, frame_length, ether_type, ip_protocol, source_address,
                dest_address, source_port, dest_port, output ready);
endinterface

interface fcwt_result_if;
  logic        valid;
  logic        ready;
  logic        is_tcp;
  logic        new_flow;
  logic [31:0] window_after;
  logic        phase_after;
  logic [47:0] tcp_total;
  logic [47:0] flow_total;

  modport source (output valid, is_tcp, new_flow, window_after, phase_after, tcp_total,
                  flow_total, input ready);
  modport sink (input valid, is_tcp, new_flow, window_after, phase_after, tcp_total,
                flow_total, output ready);
endinterface

[rtl/fcwt_cell.sv]
// ----------------------------------------------------------------------------
// fcwt_cell
// One flow entry of the recency-ordered row; trades entries with neighbors.
// ----------------------------------------------------------------------------
module fcwt_cell (
  input  logic               clk,
  input  logic               rst,
  input  fcwt_pkg::cell_ctrl_t ctrl,
  input  fcwt_pkg::entry_t   up,
  input  fcwt_pkg::entry_t   down,
  output fcwt_pkg::entry_t   entry
);
  import fcwt_pkg::*;

  entry_t entry_next;

  always_comb begin
    entry_next = entry;
    case (ctrl.op)
      OP_MATCH: begin
        entry_next.mark = entry.valid && (entry.key == ctrl.key);
      end
      OP_BUBBLE: begin
        // the marked entry swaps one place toward the front
        if (down.mark) begin
          entry_next = down;
        end else if (entry.mark) begin
          entry_next = up;
        end
      end
      OP_SHIFT: begin
        entry_next = up;
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
      entry.mark  <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
      entry.mark  <= entry_next.mark;
    end
    entry.key       <= entry_next.key;
    entry.window    <= entry_next.window;
    entry.threshold <= entry_next.threshold;
    entry.phase     <= entry_next.phase;
  end

endmodule

[rtl/fcwt_div.sv]
// ----------------------------------------------------------------------------
// fcwt_div
// Restoring 32-bit divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fcwt_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);
  import fcwt_pkg::*;

  logic [31:0] rem;
  logic [31:0] dvs;
  logic [5:0]  count;
  logic        busy;
  logic [32:0] trial;

  assign trial    = {rem, quotient[31]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 6'd0;
      end else if (busy) begin
        count <= count + 6'd1;
        if (count == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= 32'd0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (busy) begin
      if (!trial[32]) begin
        rem      <= trial[31:0];
        quotient <= {quotient[30:0], 1'b1};
      end else begin
        rem      <= {rem[30:0], quotient[31]};
        quotient <= {quotient[30:0], 1'b0};
      end
    end
  end

endmodule

[rtl/flow_congestion_window_tracker.sv]
// ----------------------------------------------------------------------------
// flow_congestion_window_tracker
// Per-flow TCP congestion window tracking over an LRU row of flow cells.
// ----------------------------------------------------------------------------
// Usage: frames carries one frame's header fields per item; results returns
// one item per frame. cfg_write/cfg_index/cfg_data load segment_size (0),
// initial_window (1) and start_threshold (2); the user must write them only
// while the block is idle, as the block itself does not enforce this.
// Flows live in a row of FLOW_ENTRIES cells kept in recency order, front
// cell most recent. The block takes one item at a time. A frame that is not
// TCP goes straight to the emit state; a new flow passes match and find,
// shifting the row by one; a known flow passes match, find and bubble while
// its entry swaps its way to the front, and in avoidance the 32-step divider.
// The next item is taken only after the result has been raised, so the
// move-to-front walk and the divider set the pace. The result sits in an
// output register; with the receiver stalled the next frame still runs up
// to its result, then the block holds until the waiting item is taken.
// Reset empties the row, clears both totals and loads the register defaults.
// ----------------------------------------------------------------------------
module flow_congestion_window_tracker #(
  parameter int unsigned FLOW_ENTRIES = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  fcwt_frame_if.sink                  frames,
  fcwt_result_if.source               results,
  input  logic                        cfg_write,
  input  logic [fcwt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                 cfg_data
);
  import fcwt_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MATCH  = 3'd1;
  localparam logic [2:0] S_FIND   = 3'd2;
  localparam logic [2:0] S_BUBBLE = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0]  state;
  logic [15:0] segment_size;
  logic [31:0] initial_window;
  logic [31:0] start_threshold;
  logic [47:0] tcp_counter;
  logic [47:0] flow_counter;
  logic [63:0] key;

  logic        res_tcp;
  logic        res_new;
  logic [31:0] res_window;
  logic        res_phase;

  entry_t      cells [FLOW_ENTRIES];
  entry_t      front;
  entry_t      empty_entry;
  logic [1:0]  op;
  logic [FLOW_ENTRIES-1:0] marks;
  logic        any_mark;

  logic        out_free;
  logic        qualifies;
  logic        div_start;
  logic        div_done;
  logic [31:0] quotient;
  logic [31:0] square;
  logic [32:0] ss_sum;
  logic [32:0] av_sum;
  logic [31:0] ss_window;
  logic [31:0] av_window;

  assign out_free  = !results.valid || results.ready;
  assign frames.ready = (state == S_IDLE);
  assign qualifies = (frames.frame_length >= MIN_FRAME) &&
                     (frames.ether_type == ETHERTYPE_IPV4) &&
                     (frames.ip_protocol == PROTO_TCP);

  always_comb begin
    for (int i = 0; i < FLOW_ENTRIES; i++) begin
      marks[i] = cells[i].mark;
    end
  end
  assign any_mark = |marks;

  assign ss_sum    = {1'b0, cells[0].window} + {17'd0, segment_size};
  assign ss_window = ss_sum[32] ? 32'hFFFF_FFFF : ss_sum[31:0];
  assign av_sum    = {1'b0, cells[0].window} + {1'b0, quotient};
  assign av_window = av_sum[32] ? 32'hFFFF_FFFF : av_sum[31:0];
  assign square    = {16'd0, segment_size} * {16'd0, segment_size};

  assign empty_entry = '0;

  // control of the row and what enters the front cell
  always_comb begin
    op        = OP_HOLD;
    front     = cells[0];
    front.mark = 1'b0;
    div_start = 1'b0;
    case (state)
      S_MATCH: op = OP_MATCH;
      S_FIND: begin
        if (!any_mark) begin
          op              = OP_SHIFT;
          front.valid     = 1'b1;
          front.key       = key;
          front.window    = initial_window;
          front.threshold = start_threshold;
          front.phase     = 1'b0;
        end
      end
      S_BUBBLE: begin
        if (!cells[0].mark) begin
          op = OP_BUBBLE;
        end else if (!cells[0].phase) begin
          op           = OP_SHIFT;
          front.window = ss_window;
          front.phase  = (ss_window >= cells[0].threshold);
        end else if (cells[0].window == 32'd0) begin
          op = OP_SHIFT;
        end else begin
          div_start = 1'b1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          op           = OP_SHIFT;
          front.window = av_window;
        end
      end
      default: op = OP_HOLD;
    endcase
  end

  genvar g;
  generate
    for (g = 0; g < FLOW_ENTRIES; g++) begin : g_cell
      cell_ctrl_t ctrl;
      entry_t     up;
      entry_t     down;
      always_comb begin
        ctrl.key = key;
        ctrl.op  = op;
        // a write of updated data touches the front cell only
        if (op == OP_SHIFT && state != S_FIND && g != 0) begin
          ctrl.op = OP_HOLD;
        end
      end
      if (g == 0) begin : g_first
        assign up = front;
      end else begin : g_mid
        assign up = cells[g-1];
      end
      if (g == FLOW_ENTRIES - 1) begin : g_last
        assign down = empty_entry;
      end else begin : g_body
        assign down = cells[g+1];
      end
      fcwt_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .ctrl  (ctrl),
        .up    (up),
        .down  (down),
        .entry (cells[g])
      );
    end
  endgenerate

  fcwt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (square),
    .divisor  (cells[0].window),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      segment_size    <= SEG_RESET;
      initial_window  <= WIN_RESET;
      start_threshold <= THR_RESET;
      tcp_counter     <= 48'd0;
      flow_counter    <= 48'd0;
      results.valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SEGMENT_SIZE:    segment_size    <= cfg_data[15:0];
          REG_INITIAL_WINDOW:  initial_window  <= cfg_data;
          REG_START_THRESHOLD: start_threshold <= cfg_data;
          default: ;
        endcase
      end
      if (results.valid && results.ready) begin
        results.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (frames.valid) begin
            if (qualifies) begin
              tcp_counter <= tcp_counter + 48'd1;
              state       <= S_MATCH;
            end else begin
              state <= S_EMIT;
            end
          end
        end
        S_MATCH: state <= S_FIND;
        S_FIND: begin
          if (!any_mark) begin
            flow_counter <= flow_counter + 48'd1;
            state        <= S_EMIT;
          end else begin
            state <= S_BUBBLE;
          end
        end
        S_BUBBLE: begin
          if (cells[0].mark) begin
            state <= (cells[0].phase && cells[0].window != 32'd0) ? S_DIV : S_EMIT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            results.valid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && frames.valid) begin
      key <= {frames.source_address, 32'd0} | {32'd0, frames.dest_address} |
             {32'd0, frames.source_port, 16'd0} | {48'd0, frames.dest_port};
      res_tcp    <= qualifies;
      res_new    <= 1'b0;
      res_window <= 32'd0;
      res_phase  <= 1'b0;
    end
    if (state == S_FIND && !any_mark) begin
      res_new    <= 1'b1;
      res_window <= initial_window;
      res_phase  <= 1'b0;
    end
    if (state == S_BUBBLE && cells[0].mark) begin
      res_window <= cells[0].phase ? cells[0].window : ss_window;
      res_phase  <= cells[0].phase || (ss_window >= cells[0].threshold);
    end
    if (state == S_DIV && div_done) begin
      res_window <= av_window;
    end
    if (state == S_EMIT && out_free) begin
      results.is_tcp       <= res_tcp;
      results.new_flow     <= res_new;
      results.window_after <= res_window;
      results.phase_after  <= res_phase;
      results.tcp_total    <= tcp_counter;
      results.flow_total   <= flow_counter;
    end
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the flow congestion window tracker. Frame headers
// go in through a bursty driver; results come back through a stalling
// monitor. Each accepted frame is run through a window predictor that keeps
// its own flow table and LRU ranks, and every result is compared field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import fcwt_pkg::*;

  localparam int unsigned ENTRIES = 1024;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [15:0] frame_length;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
  } frame_t;

  typedef struct packed {
    logic        is_tcp;
    logic        new_flow;
    logic [31:0] window_after;
    logic        phase_after;
    logic [47:0] tcp_total;
    logic [47:0] flow_total;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  fcwt_frame_if  frames ();
  fcwt_result_if results ();

  flow_congestion_window_tracker #(.FLOW_ENTRIES(ENTRIES)) u_dut (
    .clk(clk), .rst(rst), .frames(frames.sink), .results(results.source),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predicted flow table
  logic [15:0] seg_size;
  logic [31:0] init_win;
  logic [31:0] start_thr;
  logic        fl_valid [ENTRIES];
  logic [63:0] fl_key [ENTRIES];
  logic [31:0] fl_win [ENTRIES];
  logic [31:0] fl_thr [ENTRIES];
  logic        fl_phase [ENTRIES];
  int unsigned fl_rank [ENTRIES];
  logic [47:0] tcp_count;
  logic [47:0] flow_count;

  frame_t   pending_frames[$];
  verdict_t expected_verdicts[$];
  int       mismatches = 0;
  bit       frame_taken = 0;
  int       hold_cycles = 0;

  // Move entry idx to the front; entries more recent than old_rank age by one.
  function automatic void promote(int unsigned idx, int unsigned old_rank);
    for (int unsigned i = 0; i < ENTRIES; i++) begin
      if (i != idx && fl_valid[i] && fl_rank[i] < old_rank) fl_rank[i]++;
    end
    fl_rank[idx] = 0;
  endfunction

  function automatic verdict_t predict_window(frame_t f);
    verdict_t    v;
    logic [63:0] key;
    logic [63:0] sum;
    int unsigned hit;
    int unsigned slot;
    int unsigned best;
    int unsigned old_rank;
    v = '0;
    if (f.frame_length < MIN_FRAME || f.ether_type != ETHERTYPE_IPV4 ||
        f.ip_protocol != PROTO_TCP) begin
      v.tcp_total = tcp_count;
      v.flow_total = flow_count;
      return v;
    end
    tcp_count = tcp_count + 48'd1;
    key = {f.source_address, 32'd0} | {32'd0, f.dest_address} |
          {32'd0, f.source_port, 16'd0} | {48'd0, f.dest_port};
    hit = ENTRIES;
    for (int unsigned i = 0; i < ENTRIES; i++) begin
      if (hit == ENTRIES && fl_valid[i] && fl_key[i] == key) hit = i;
    end
    if (hit == ENTRIES) begin
      slot = ENTRIES;
      for (int unsigned i = 0; i < ENTRIES; i++) begin
        if (slot == ENTRIES && !fl_valid[i]) slot = i;
      end
      if (slot == ENTRIES) begin
        // Table full: evict the oldest rank, lowest index on a tie
        best = 0;
        slot = 0;
        for (int unsigned i = 0; i < ENTRIES; i++) begin
          if (fl_rank[i] > best) begin
            best = fl_rank[i];
            slot = i;
          end
        end
        old_rank = best;
      end else begin
        old_rank = ENTRIES;
      end
      fl_valid[slot] = 1'b1;
      fl_key[slot] = key;
      fl_win[slot] = init_win;
      fl_thr[slot] = start_thr;
      fl_phase[slot] = 1'b0;
      promote(slot, old_rank);
      flow_count = flow_count + 48'd1;
      v.new_flow = 1'b1;
      v.window_after = init_win;
    end else begin
      sum = {32'd0, fl_win[hit]};
      if (!fl_phase[hit]) begin
        sum = sum + {48'd0, seg_size};
        if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
        if (sum[31:0] >= fl_thr[hit]) fl_phase[hit] = 1'b1;
      end else if (sum != 0) begin
        sum = sum + (64'(seg_size) * 64'(seg_size)) / sum;
        if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
      end
      fl_win[hit] = sum[31:0];
      v.window_after = sum[31:0];
      v.phase_after = fl_phase[hit];
      promote(hit, fl_rank[hit]);
    end
    v.is_tcp = 1'b1;
    v.tcp_total = tcp_count;
    v.flow_total = flow_count;
    return v;
  endfunction

  // Input side: predict each accepted item
  always @(posedge clk) begin
    if (!rst && frames.valid && frames.ready) begin
      expected_verdicts.push_back(predict_window({frames.frame_length, frames.ether_type,
        frames.ip_protocol, frames.source_address, frames.dest_address,
        frames.source_port, frames.dest_port}));
      frame_taken = 1;
    end
  end

  // Driver: bursts of items with random gaps
  int burst_left = 4;
  int gap_left = 0;
  always @(negedge clk) begin
    logic   drive;
    frame_t f;
    drive = 1'b0;
    f = '0;
    if (rst) begin
      frames.valid <= 1'b0;
    end else if (frames.valid && !frame_taken) begin
      // hold the offered item
    end else begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_frames.size() != 0) begin
        f = pending_frames.pop_front();
        drive = 1'b1;
        if (--burst_left <= 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      frames.valid <= drive;
      if (drive) begin
        frames.frame_length <= f.frame_length;
        frames.ether_type <= f.ether_type;
        frames.ip_protocol <= f.ip_protocol;
        frames.source_address <= f.source_address;
        frames.dest_address <= f.dest_address;
        frames.source_port <= f.source_port;
        frames.dest_port <= f.dest_port;
      end
    end
    frame_taken = 0;
  end

  // Receiver: the stall rate drifts, redrawn each time stall_age wraps; long hold-off on request
  int stall_pct = 0;
  int stall_age = 0;
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      results.ready <= 1'b0;
    end else begin
      if (++stall_age == 64) begin
        stall_age = 0;
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
      end
      results.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
    end
  endtask

  // Monitor: compare each accepted result against the oldest prediction
  always @(posedge clk) begin
    verdict_t e;
    if (!rst && results.valid && results.ready) begin
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual window %h", $realtime,
                 results.window_after);
      end else begin
        e = expected_verdicts.pop_front();
        check_field("is_tcp", 64'(e.is_tcp), 64'(results.is_tcp));
        check_field("new_flow", 64'(e.new_flow), 64'(results.new_flow));
        check_field("window_after", 64'(e.window_after), 64'(results.window_after));
        check_field("phase_after", 64'(e.phase_after), 64'(results.phase_after));
        check_field("tcp_total", 64'(e.tcp_total), 64'(results.tcp_total));
        check_field("flow_total", 64'(e.flow_total), 64'(results.flow_total));
      end
    end
  end

  task automatic push_tcp(logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
                          logic [15:0] dp);
    pending_frames.push_back({16'($urandom_range(54, 65535)), ETHERTYPE_IPV4, PROTO_TCP,
                              sa, da, sp, dp});
  endtask

  // Noise: one field broken, or everything random
  task automatic push_noise();
    frame_t f;
    f = {16'($urandom_range(54, 65535)), ETHERTYPE_IPV4, PROTO_TCP, 32'($urandom),
         32'($urandom), 16'($urandom), 16'($urandom)};
    case ($urandom_range(0, 3))
      0: f.frame_length = 16'($urandom_range(0, 53));
      1: f.ether_type = 16'($urandom);
      2: f.ip_protocol = 8'($urandom);
      default: begin
        f.frame_length = 16'($urandom);
        f.ether_type = 16'($urandom);
        f.ip_protocol = 8'($urandom);
      end
    endcase
    pending_frames.push_back(f);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_SEGMENT_SIZE) seg_size = data[15:0];
    else if (idx == REG_INITIAL_WINDOW) init_win = data;
    else if (idx == REG_START_THRESHOLD) start_thr = data;
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_frames.size() != 0 || frames.valid || expected_verdicts.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic configure(logic [31:0] seg, logic [31:0] win, logic [31:0] thr);
    wait_idle();
    write_reg(REG_SEGMENT_SIZE, seg);
    write_reg(REG_INITIAL_WINDOW, win);
    write_reg(REG_START_THRESHOLD, thr);
  endtask

  // Random traffic over a small pool of recurring flows
  task automatic pool_traffic(int count);
    logic [31:0] sa [16];
    logic [31:0] da [16];
    logic [15:0] sp [16];
    logic [15:0] dp [16];
    int k;
    for (int i = 0; i < 16; i++) begin
      sa[i] = $urandom; da[i] = $urandom; sp[i] = 16'($urandom); dp[i] = 16'($urandom);
    end
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, 15);
      if ($urandom_range(0, 99) < 15) begin
        push_noise();
      end else begin
        if ($urandom_range(0, 99) < 8) begin
          sa[k] = $urandom; da[k] = $urandom; sp[k] = 16'($urandom); dp[k] = 16'($urandom);
        end
        push_tcp(sa[k], da[k], sp[k], dp[k]);
      end
    end
  endtask

  initial begin
    logic [31:0] early_src;
    for (int i = 0; i < ENTRIES; i++) begin
      fl_valid[i] = 1'b0;
      fl_key[i] = '0;
      fl_win[i] = '0;
      fl_thr[i] = '0;
      fl_phase[i] = 1'b0;
      fl_rank[i] = 0;
    end
    seg_size = SEG_RESET;
    init_win = WIN_RESET;
    start_thr = THR_RESET;
    tcp_count = '0;
    flow_count = '0;
    frames.valid = 1'b0;
    frames.frame_length = '0;
    frames.ether_type = '0;
    frames.ip_protocol = '0;
    frames.source_address = '0;
    frames.dest_address = '0;
    frames.source_port = '0;
    frames.dest_port = '0;
    results.ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: boundaries, non-TCP cases and overlapping keys
    pending_frames.push_back({16'd54, ETHERTYPE_IPV4, PROTO_TCP, 32'h0a000001,
                              32'h0a000002, 16'd1000, 16'd80});
    pending_frames.push_back({16'd54, ETHERTYPE_IPV4, PROTO_TCP, 32'h0a000001,
                              32'h0a000002, 16'd1000, 16'd80});
    pending_frames.push_back({16'd53, ETHERTYPE_IPV4, PROTO_TCP, 32'h0a000001,
                              32'h0a000002, 16'd1000, 16'd80});
    pending_frames.push_back({16'd60, 16'h0008, PROTO_TCP, 32'h1, 32'h2, 16'd3, 16'd4});
    pending_frames.push_back({16'd60, ETHERTYPE_IPV4, 8'd17, 32'h1, 32'h2, 16'd3, 16'd4});
    pending_frames.push_back({16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                              16'hFFFF, 16'hFFFF});
    pending_frames.push_back({16'hFFFF, ETHERTYPE_IPV4, PROTO_TCP, 32'hFFFFFFFF,
                              32'hFFFFFFFF, 16'hFFFF, 16'hFFFF});
    pending_frames.push_back({16'd0, 16'd0, 8'd0, 32'd0, 32'd0, 16'd0, 16'd0});
    pending_frames.push_back({16'd100, ETHERTYPE_IPV4, PROTO_TCP, 32'd0, 32'd0, 16'd0, 16'd0});
    // Address and port bits overlap: these two tuples share a key
    push_tcp(32'h55, 32'h00010002, 16'd0, 16'd0);
    push_tcp(32'h55, 32'h0, 16'd1, 16'd2);
    for (int i = 0; i < 8; i++) push_tcp(32'h0a000001, 32'h0a000002, 16'd1000, 16'd80);

    // Zero registers, with junk in unused bits and a write to no register
    configure(32'hABCD_0000, 32'd0, 32'd0);
    write_reg(REG_UNUSED, 32'h1234_5678);
    for (int i = 0; i < 3; i++) push_tcp(32'h77, 32'h88, 16'd9, 16'd10);

    // Saturation at the top of the window
    configure(32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    for (int i = 0; i < 3; i++) push_tcp(32'h99, 32'haa, 16'd11, 16'd12);

    // Random traffic under several settings; stall the receiver for a long stretch
    configure(32'd1460, 32'd14600, 32'd65535);
    hold_cycles = 3000;
    pool_traffic(8);
    configure(32'd1, 32'd1, 32'd2);
    pool_traffic(8);
    configure(32'd65535, 32'd100, 32'd400000);
    pool_traffic(8);
    configure($urandom_range(1, 65535), $urandom, $urandom_range(1, 200000));
    pool_traffic(8);

    // Fill the table past capacity so the oldest flows are evicted
    configure(32'd1460, 32'd14600, 32'd65535);
    early_src = 32'h4000_0000;
    for (int n = 0; n < 1010; n++) begin
      if (n % 100 == 99) push_tcp(early_src + $urandom_range(0, n / 2), 32'h0, 16'd7, 16'd7);
      else push_tcp(early_src + n, 32'h0, 16'd7, 16'd7);
    end

    wait_idle();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
